[sv/video_mode_byte_to_planar_top_macros.svh]
// ----------------------------------------------------------------------------
// video mode byte to planar: assertion macros
// shared check forms for the planar converter, clocked on clk
// ----------------------------------------------------------------------------
`ifndef VIDEO_MODE_BYTE_TO_PLANAR_TOP_MACROS_SVH
`define VIDEO_MODE_BYTE_TO_PLANAR_TOP_MACROS_SVH

// check that holds outside reset
`define VMBP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// check that also holds while reset is applied
`define VMBP_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/vmbp_pkg.sv]
// ----------------------------------------------------------------------------
// vmbp_pkg
// types and constants for the video mode byte to planar converter
// ----------------------------------------------------------------------------
`default_nettype none

package vmbp_pkg;

	typedef enum logic [1:0] {
		MODE_STD   = 2'd0,
		MODE_HIRES = 2'd1,
		MODE_BM4   = 2'd2,
		MODE_BM16  = 2'd3
	} mode_t;

	localparam logic [2:0] COUNT_FULL = 3'd4;
	localparam logic [2:0] COUNT_HALF = 3'd2;

	localparam logic [7:0] BYTE_ZERO = 8'h00;
	localparam logic [7:0] BYTE_ONES = 8'hff;

	localparam logic [7:0] PAIR_FORM_HI = 8'hc0;
	localparam logic [7:0] PAIR_FORM_LO = 8'h30;
	localparam logic [7:0] PAIR_ATTR_HI = 8'h0c;
	localparam logic [7:0] PAIR_ATTR_LO = 8'h03;

	localparam int unsigned NUM_PLANES = 4;

	typedef struct packed {
		logic [7:0] form_byte;
		logic [7:0] attr_byte;
	} in_item_t;

	typedef struct packed {
		logic [2:0] byte_count;
		logic [7:0] plane3_byte;
		logic [7:0] plane2_byte;
		logic [7:0] plane1_byte;
		logic [7:0] plane0_byte;
	} out_item_t;

endpackage

`default_nettype wire

[sv/vmbp_convert.sv]
// ----------------------------------------------------------------------------
// vmbp_convert
// mode dependent mapping of a form / attribute pair onto four plane bytes
// ----------------------------------------------------------------------------
`default_nettype none

module vmbp_convert (
	input  wire vmbp_pkg::mode_t     mode,
	input  wire vmbp_pkg::in_item_t  item_in,
	output vmbp_pkg::out_item_t      item_out
);

	logic [3:0] fg;
	logic [3:0] bg;
	logic [7:0] std_p  [vmbp_pkg::NUM_PLANES];
	logic [7:0] bm16_p [vmbp_pkg::NUM_PLANES];
	logic [7:0] form;
	logic [7:0] attr;

	assign form = item_in.form_byte;
	assign attr = item_in.attr_byte;

	// color codes with inverted top bit
	assign fg = {~attr[6], attr[5:3]};
	assign bg = {~attr[7], attr[2:0]};

	always_comb begin
		for (int k = 0; k < vmbp_pkg::NUM_PLANES; k++) begin
			case ({fg[k], bg[k]})
				2'b11: std_p[k] = vmbp_pkg::BYTE_ONES;
				2'b10: std_p[k] = form;
				2'b01: std_p[k] = ~form;
				default: std_p[k] = vmbp_pkg::BYTE_ZERO;
			endcase
			bm16_p[k] = (form[4 + k] ? vmbp_pkg::PAIR_FORM_HI : vmbp_pkg::BYTE_ZERO)
				| (form[k] ? vmbp_pkg::PAIR_FORM_LO : vmbp_pkg::BYTE_ZERO)
				| (attr[4 + k] ? vmbp_pkg::PAIR_ATTR_HI : vmbp_pkg::BYTE_ZERO)
				| (attr[k] ? vmbp_pkg::PAIR_ATTR_LO : vmbp_pkg::BYTE_ZERO);
		end
	end

	always_comb begin
		case (mode)
			vmbp_pkg::MODE_STD: begin
				item_out.plane0_byte = std_p[0];
				item_out.plane1_byte = std_p[1];
				item_out.plane2_byte = std_p[2];
				item_out.plane3_byte = std_p[3];
				item_out.byte_count  = vmbp_pkg::COUNT_FULL;
			end
			vmbp_pkg::MODE_HIRES: begin
				item_out.plane0_byte = form;
				item_out.plane1_byte = attr;
				item_out.plane2_byte = vmbp_pkg::BYTE_ZERO;
				item_out.plane3_byte = vmbp_pkg::BYTE_ZERO;
				item_out.byte_count  = vmbp_pkg::COUNT_HALF;
			end
			vmbp_pkg::MODE_BM4: begin
				item_out.plane0_byte = attr;
				item_out.plane1_byte = form;
				item_out.plane2_byte = vmbp_pkg::BYTE_ZERO;
				item_out.plane3_byte = vmbp_pkg::BYTE_ZERO;
				item_out.byte_count  = vmbp_pkg::COUNT_HALF;
			end
			default: begin
				item_out.plane0_byte = bm16_p[0];
				item_out.plane1_byte = bm16_p[1];
				item_out.plane2_byte = bm16_p[2];
				item_out.plane3_byte = bm16_p[3];
				item_out.byte_count  = vmbp_pkg::COUNT_FULL;
			end
		endcase
	end

endmodule

`default_nettype wire

[sv/video_mode_byte_to_planar_top.sv]
// an accepted item is held in the input register, then in the result register, which offers it on the master side
// throughput: one item per cycle, sustained while the master side takes each result
// the input register and the result register both advance in the same cycle,
// so the stream keeps moving as long as m_tready is high
// reset: arst_n clears both valid flags and sets mode_q to standard
// ----------------------------------------------------------------------------
// video_mode_byte_to_planar_top
// converts form / attribute byte pairs into planar bytes per screen mode
// ----------------------------------------------------------------------------
`default_nettype none

`include "video_mode_byte_to_planar_top_macros.svh"

module video_mode_byte_to_planar_top (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        cfg_we,
	input  wire [1:0]  cfg_wdata,
	input  wire        s_tvalid,
	output logic       s_tready,
	input  wire [15:0] s_tdata,   // form_byte, attr_byte
	output logic       m_tvalid,
	input  wire        m_tready,
	output logic [39:0] m_tdata   // plane0..plane3 bytes, byte_count, zero pad
);

	vmbp_pkg::mode_t     mode_q;
	logic                valid_s1;
	vmbp_pkg::in_item_t  item_s1;
	logic                valid_s2;
	vmbp_pkg::out_item_t item_s2;
	vmbp_pkg::out_item_t conv;
	logic                adv_s2;
	logic                adv_s1;
	logic                half_mode;
	logic                full_mode;
	logic                half_ok;
	logic                full_ok;

	assign adv_s2   = !valid_s2 || m_tready;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign s_tready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= vmbp_pkg::MODE_STD;
		end else if (cfg_we) begin
			mode_q <= vmbp_pkg::mode_t'(cfg_wdata);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= s_tvalid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && s_tvalid) begin
			item_s1.form_byte <= s_tdata[7:0];
			item_s1.attr_byte <= s_tdata[15:8];
		end
		if (adv_s2 && valid_s1) begin
			item_s2 <= conv;
		end
	end

	vmbp_convert u_convert (
		.mode     (mode_q),
		.item_in  (item_s1),
		.item_out (conv)
	);

	assign m_tvalid = valid_s2;
	assign m_tdata  = {5'd0, item_s2};

	// checks
	assign half_mode = mode_q inside {vmbp_pkg::MODE_HIRES, vmbp_pkg::MODE_BM4};
	assign full_mode = mode_q inside {vmbp_pkg::MODE_STD, vmbp_pkg::MODE_BM16};
	assign half_ok   = (item_s2.byte_count == vmbp_pkg::COUNT_HALF)
		&& (item_s2.plane2_byte == vmbp_pkg::BYTE_ZERO)
		&& (item_s2.plane3_byte == vmbp_pkg::BYTE_ZERO);
	assign full_ok   = item_s2.byte_count == vmbp_pkg::COUNT_FULL;

	`VMBP_ASSERT_RST(a_no_valid_in_reset, !arst_n |=> !m_tvalid, "result valid during reset")
	`VMBP_ASSERT(a_s1_moves_on, (valid_s1 && adv_s2) |=> m_tvalid, "stage one item lost")
	`VMBP_ASSERT(a_half_modes, (m_tvalid && half_mode) |-> half_ok, "half mode result malformed")
	`VMBP_ASSERT(a_full_modes, (m_tvalid && full_mode) |-> full_ok, "full mode count wrong")

endmodule

`default_nettype wire
